### hdl/pil_pkg.sv
// Shared types and codes for the positional insert list.
// Used by pil_ctrl, pil_datapath and positional_insert_list.
`default_nettype none

package pil_pkg;

  // Operation codes carried by a request
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       insert;     // shift back from position and write value
    logic       delete;     // shift the cells forward by one; the last cell keeps its value
    logic       rotate;     // move the front entry to the tail
    logic       load_rem;   // load remaining display count
    logic       dec_rem;    // count one display result off
    logic       emit;       // register a result this cycle
    logic       take_head;  // result value is the front entry
    logic       last;       // result closes the request
    logic [1:0] status;
  } cmd_t;

  // Flags from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic pos_ok;
    logic count_one;
    logic rem_one;
  } flags_t;

endpackage

`default_nettype wire

### hdl/pil_ctrl.sv
// Controller for the positional insert list: decodes requests and sequences display.
// Depends on pil_pkg for command, flag and code definitions.
`default_nettype none

module pil_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      op,
  input  wire pil_pkg::flags_t flags,
  output pil_pkg::cmd_t        cmd,
  output logic                 busy
);

  typedef enum logic {S_IDLE, S_DISPLAY} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.status = pil_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          unique case (op)
            pil_pkg::OP_INSERT: begin
              priority if (!flags.pos_ok) begin
                cmd.status = pil_pkg::ST_BADPOS;
              end else if (flags.full) begin
                cmd.status = pil_pkg::ST_FULL;
              end else begin
                cmd.insert = 1'b1;
              end
            end
            pil_pkg::OP_DELETE: begin
              if (flags.empty) begin
                cmd.status = pil_pkg::ST_EMPTY;
              end else begin
                cmd.delete    = 1'b1;
                cmd.take_head = 1'b1;
              end
            end
            pil_pkg::OP_DISPLAY: begin
              if (flags.empty) begin
                cmd.status = pil_pkg::ST_EMPTY;
              end else begin
                cmd.rotate    = 1'b1;
                cmd.take_head = 1'b1;
                cmd.last      = flags.count_one;
                if (!flags.count_one) begin
                  cmd.load_rem = 1'b1;
                  state_next   = S_DISPLAY;
                end
              end
            end
            default: begin
              // unused code: report the count and change nothing
            end
          endcase
        end
      end
      S_DISPLAY: begin
        cmd.emit      = 1'b1;
        cmd.rotate    = 1'b1;
        cmd.take_head = 1'b1;
        cmd.dec_rem   = 1'b1;
        cmd.last      = flags.rem_one;
        if (flags.rem_one) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state == S_DISPLAY);

endmodule

`default_nettype wire

### hdl/pil_datapath.sv
// Datapath for the positional insert list: entry cells, count, display counter
// and result registers. Depends on pil_pkg for command and flag structs.
`default_nettype none

module pil_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         position,
  input  wire pil_pkg::cmd_t      cmd,
  output pil_pkg::flags_t         flags,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic signed [31:0]      value_out,
  output logic [4:0]              count_out,
  output logic                    last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;

  logic signed [31:0] entries      [DEPTH];
  logic signed [31:0] entries_next [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      rem;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      limit_ext;

  assign pos_ext   = PW'(position);
  assign limit_ext = PW'(count) + PW'(1);

  assign flags.empty     = (count == '0);
  assign flags.full      = (count == CW'(DEPTH));
  assign flags.pos_ok    = (position != 8'd0) && (pos_ext <= limit_ext);
  assign flags.count_one = (count == CW'(1));
  assign flags.rem_one   = (rem == CW'(1));

  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CW'(1);
    end else if (cmd.delete) begin
      count_next = count - CW'(1);
    end
  end

  // Cells take a neighbour, cell 0 or value; none is read at a chosen address
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (cmd.insert) begin
        if (i > 0 && PW'(i) >= pos_ext) begin
          entries_next[i] = entries[(i > 0) ? i - 1 : 0];
        end else if (PW'(i) + PW'(1) == pos_ext) begin
          entries_next[i] = value;
        end
      end else if (cmd.delete) begin
        if (i < DEPTH - 1) begin
          entries_next[i] = entries[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd.rotate) begin
        // front entry wraps to the tail so the list is restored after a full pass
        if ((PW'(i) + PW'(1)) == PW'(count)) begin
          entries_next[i] = entries[0];
        end else if (i < DEPTH - 1) begin
          entries_next[i] = entries[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries[i] <= entries_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rem    <= '0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= cmd.emit;
      if (cmd.load_rem) begin
        rem <= count - CW'(1);
      end else if (cmd.dec_rem) begin
        rem <= rem - CW'(1);
      end
    end
  end

  // Result payload, valid while strobe is high
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status    <= cmd.status;
      value_out <= cmd.take_head ? entries[0] : 32'sd0;
      count_out <= 5'(count_next);
      last      <= cmd.last;
    end
  end

endmodule

`default_nettype wire

### hdl/positional_insert_list.sv
// Top level of the positional insert list: controller plus datapath.
// Depends on pil_pkg, pil_ctrl and pil_datapath.
//
//   channel   ports                                      handshake
//   request   op, value, position                        start & !busy
//   result    status, value_out, count_out, last         strobe, one cycle
//
// Insert, delete and error requests give one result in the cycle after the
// request; a new request may follow at once. Display of n entries gives n
// results on consecutive cycles, rotating the front cell to the tail each
// cycle; busy stays high while the controller issues the remaining results. The receiver
// cannot stall. Synchronous reset empties the list and clears the strobe.
`default_nettype none

module positional_insert_list #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] value,
  input  wire logic [7:0]         position,
  output logic                    busy,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic signed [31:0]      value_out,
  output logic [4:0]              count_out,
  output logic                    last
);

  pil_pkg::cmd_t   cmd;
  pil_pkg::flags_t flags;

  pil_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .flags (flags),
    .cmd   (cmd),
    .busy  (busy)
  );

  pil_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .position  (position),
    .cmd       (cmd),
    .flags     (flags),
    .strobe    (strobe),
    .status    (status),
    .value_out (value_out),
    .count_out (count_out),
    .last      (last)
  );

endmodule

`default_nettype wire
